@@ rtl/ssc_pkg.sv @@
// Shared types, class codes and character constants for the SQL script
// character classifier. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ssc_pkg;

  localparam logic [2:0] CLS_QUERY   = 3'd0;
  localparam logic [2:0] CLS_DELIM   = 3'd1;
  localparam logic [2:0] CLS_STRING  = 3'd2;
  localparam logic [2:0] CLS_LINE    = 3'd3;
  localparam logic [2:0] CLS_BLOCK   = 3'd4;
  localparam logic [2:0] CLS_KEYWORD = 3'd5;
  localparam logic [2:0] CLS_VALUE   = 3'd6;
  localparam logic [2:0] CLS_NONE    = 3'd7;

  localparam int KEYWORD_LEN = 9;

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_LOW_D  = 8'h64;
  localparam logic [7:0] CH_UP_D   = 8'h44;

  // Broadcast controls for the window cells.
  typedef struct packed {
    logic       shift;
    logic [7:0] push_byte;
    logic [7:0] dwr_byte;
    logic       restart;
  } cell_ctl_t;

  // What each cell reports back.
  typedef struct packed {
    logic [7:0] win_byte;
    logic       valid;
    logic       delim_ok;
    logic       delim_has;
    logic       kw_ok;
  } cell_stat_t;

  // What the labeler sees of the window head.
  typedef struct packed {
    logic [7:0] head;
    logic [7:0] next_byte;
    logic       next_valid;
    logic       delim_match;
    logic       kw_match;
    logic       delim_has;
  } head_view_t;

  // Delimiter store write request from the labeler.
  typedef struct packed {
    logic       en;
    logic [7:0] wbyte;
  } dwr_t;

  function automatic logic [7:0] kw_char(input int idx);
    logic [7:0] ch;
    case (idx)
      0:       ch = 8'h44; // D
      1:       ch = 8'h45; // E
      2:       ch = 8'h4C; // L
      3:       ch = 8'h49; // I
      4:       ch = 8'h4D; // M
      5:       ch = 8'h49; // I
      6:       ch = 8'h54; // T
      7:       ch = 8'h45; // E
      8:       ch = 8'h52; // R
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? (c - 8'd32) : c;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h85 || c == 8'hA0;
  endfunction

endpackage
`default_nettype wire

@@ rtl/ssc_in_if.sv @@
// Input channel of the classifier: one script byte per word.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface ssc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_last;

  modport source (output valid, output char_byte, output is_last, input ready);
  modport sink   (input valid, input char_byte, input is_last, output ready);
endinterface
`default_nettype wire

@@ rtl/ssc_out_if.sv @@
// Result channel of the classifier: one labeled byte per word.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface ssc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] char_class;
  logic [7:0] char_out;
  logic       last_out;

  modport source (output valid, output char_class, output char_out, output last_out,
                  input ready);
  modport sink   (input valid, input char_class, input char_out, input last_out,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/ssc_cell.sv @@
// One cell of the lookahead chain: a window byte, its valid bit and one
// delimiter byte, with local compares. Depends on ssc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssc_cell #(
  parameter int K = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ssc_pkg::cell_ctl_t    ctl,
  input  logic                  push_sel,
  input  logic                  dwr_sel,
  input  logic                  delim_act,
  input  logic [7:0]            nb_byte,
  input  logic                  nb_valid,
  input  logic [7:0]            probe,
  output ssc_pkg::cell_stat_t   stat
);

  logic [7:0] win_r;
  logic       valid_r;
  logic [7:0] delim_r;

  always_ff @(posedge clk) begin
    if (push_sel) begin
      win_r <= ctl.push_byte;
    end else if (ctl.shift) begin
      win_r <= nb_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push_sel) begin
      valid_r <= 1'b1;
    end else if (ctl.shift) begin
      valid_r <= nb_valid;
    end
  end

  // The head cell restores the default semicolon delimiter on reset and
  // at the end of every script.
  always_ff @(posedge clk) begin
    if ((!rst_n || ctl.restart) && K == 0) begin
      delim_r <= ssc_pkg::CH_SEMI;
    end else if (dwr_sel) begin
      delim_r <= ctl.dwr_byte;
    end
  end

  assign stat.win_byte  = win_r;
  assign stat.valid     = valid_r;
  assign stat.delim_ok  = !delim_act || (valid_r && win_r == delim_r);
  assign stat.delim_has = delim_act && (delim_r == probe);
  assign stat.kw_ok     = (K >= ssc_pkg::KEYWORD_LEN) ||
                          (valid_r && ssc_pkg::to_upper(win_r) == ssc_pkg::kw_char(K));

endmodule
`default_nettype wire

@@ rtl/ssc_label.sv @@
// Class state machine that labels the byte at the head of the window and
// owns the delimiter length. Depends on ssc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssc_label #(
  parameter int WINDOW = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic                        restart,
  input  ssc_pkg::head_view_t         hv,
  output logic [2:0]                  cls,
  output logic [$clog2(WINDOW+1)-1:0] delim_len,
  output ssc_pkg::dwr_t               dwr
);

  localparam int CW = $clog2(WINDOW + 1);

  logic [2:0]    cls_r, cls_nxt;
  logic [2:0]    pend_r, pend_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic          bs_r, bs_nxt;
  logic [7:0]    prev_r;
  logic [2:0]    cur;

  always_comb begin
    cur      = (pend_r != ssc_pkg::CLS_NONE) ? pend_r : cls_r;
    cls_nxt  = cur;
    pend_nxt = ssc_pkg::CLS_NONE;
    len_nxt  = len_r;
    dwr.en   = 1'b0;
    dwr.wbyte = hv.head;
    unique case (cur)
      ssc_pkg::CLS_QUERY: begin
        if (hv.delim_match) begin
          cls_nxt = ssc_pkg::CLS_DELIM;
          if (len_r == CW'(1)) begin
            pend_nxt = ssc_pkg::CLS_QUERY;
          end
        end else if (hv.head == ssc_pkg::CH_LOW_D || hv.head == ssc_pkg::CH_UP_D) begin
          if (hv.kw_match) begin
            cls_nxt = ssc_pkg::CLS_KEYWORD;
          end
        end else if (hv.head == ssc_pkg::CH_SLASH) begin
          if (hv.next_valid && hv.next_byte == ssc_pkg::CH_STAR) begin
            cls_nxt = ssc_pkg::CLS_BLOCK;
          end
        end else if (hv.head == ssc_pkg::CH_DASH) begin
          if (hv.next_valid && hv.next_byte == ssc_pkg::CH_DASH) begin
            cls_nxt = ssc_pkg::CLS_LINE;
          end
        end else if (hv.head == ssc_pkg::CH_QUOTE) begin
          cls_nxt = ssc_pkg::CLS_STRING;
        end
      end
      ssc_pkg::CLS_DELIM: begin
        if (hv.next_valid && !hv.delim_has) begin
          pend_nxt = ssc_pkg::CLS_QUERY;
        end
      end
      ssc_pkg::CLS_STRING: begin
        if (hv.head == ssc_pkg::CH_QUOTE && !bs_r) begin
          pend_nxt = ssc_pkg::CLS_QUERY;
        end
      end
      ssc_pkg::CLS_LINE: begin
        if (hv.head == ssc_pkg::CH_LF) begin
          cls_nxt = ssc_pkg::CLS_QUERY;
        end
      end
      ssc_pkg::CLS_BLOCK: begin
        if (hv.head == ssc_pkg::CH_SLASH && prev_r == ssc_pkg::CH_STAR) begin
          pend_nxt = ssc_pkg::CLS_QUERY;
        end
      end
      ssc_pkg::CLS_KEYWORD: begin
        if (ssc_pkg::is_space(hv.head)) begin
          len_nxt  = '0;
          pend_nxt = ssc_pkg::CLS_VALUE;
        end
      end
      ssc_pkg::CLS_VALUE: begin
        if (ssc_pkg::is_space(hv.head)) begin
          pend_nxt = ssc_pkg::CLS_QUERY;
        end else if (len_r < CW'(WINDOW)) begin
          dwr.en  = go;
          len_nxt = len_r + CW'(1);
        end
      end
      default: begin
        cls_nxt = ssc_pkg::CLS_QUERY;
      end
    endcase
    bs_nxt = (hv.head == ssc_pkg::CH_BSLASH) ? !bs_r : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (go && restart)) begin
      cls_r  <= ssc_pkg::CLS_QUERY;
      pend_r <= ssc_pkg::CLS_NONE;
      len_r  <= CW'(1);
      bs_r   <= 1'b0;
      prev_r <= 8'h00;
    end else if (go) begin
      cls_r  <= cls_nxt;
      pend_r <= pend_nxt;
      len_r  <= len_nxt;
      bs_r   <= bs_nxt;
      prev_r <= hv.head;
    end
  end

  assign cls       = cls_nxt;
  assign delim_len = len_r;

endmodule
`default_nettype wire

@@ rtl/sql_script_char_classifier.sv @@
// Top level of the SQL script character classifier: lookahead cell chain,
// head labeler and output register. Depends on ssc_pkg, ssc_in_if,
// ssc_out_if, ssc_cell and ssc_label.
//
//   Channel  Dir  Word contents                     Accepted when
//   in_ch    in   char_byte, is_last                valid && ready
//   out_ch   out  char_class, char_out, last_out    valid && ready
//
// While out_ch is not stalled, one byte enters and one labeled byte leaves
// every cycle in steady state; a byte is labeled once WINDOW-1 later bytes
// sit in the chain. A byte marked last starts a flush of the chain, one label
// per cycle while out_ch is not stalled, during which in_ch.ready is low.
// Reset is synchronous; there is no clearing pass.
// A stalled out_ch holds its word; input is still taken until the chain fills.
`timescale 1ns / 1ps
`default_nettype none
module sql_script_char_classifier #(
  parameter int WINDOW = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  ssc_in_if.sink          in_ch,
  ssc_out_if.source       out_ch
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int IW = $clog2(WINDOW);

  ssc_pkg::cell_ctl_t  ctl;
  ssc_pkg::cell_stat_t stat [WINDOW];
  ssc_pkg::head_view_t hv;
  ssc_pkg::dwr_t       dwr;

  logic [WINDOW-1:0] push_sel, dwr_sel, delim_act;
  logic [WINDOW-1:0] delim_ok_v, delim_has_v, kw_ok_v;
  logic [CW-1:0]     fill_r, fill_nxt, widx, delim_len;
  logic              flush_r;
  logic              full, slot_free, go, push, final_byte;
  logic [2:0]        cls;

  logic       out_valid_r;
  logic [2:0] out_class_r;
  logic [7:0] out_char_r;
  logic       out_last_r;

  assign full       = stat[WINDOW-1].valid;
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign go         = (full || flush_r) && stat[0].valid && slot_free;
  assign in_ch.ready = !flush_r && (!full || go);
  assign push       = in_ch.valid && in_ch.ready;
  assign final_byte = flush_r && !stat[1].valid;

  // After a pop the write slot moves down by one.
  assign widx     = go ? (fill_r - CW'(1)) : fill_r;
  assign fill_nxt = fill_r + CW'(push) - CW'(go);

  assign ctl.shift     = go;
  assign ctl.push_byte = in_ch.char_byte;
  assign ctl.dwr_byte  = dwr.wbyte;
  assign ctl.restart   = go && final_byte;

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    logic [7:0] nb_byte;
    logic       nb_valid;

    if (k == WINDOW - 1) begin : g_tail
      assign nb_byte  = 8'h00;
      assign nb_valid = 1'b0;
    end else begin : g_mid
      assign nb_byte  = stat[k+1].win_byte;
      assign nb_valid = stat[k+1].valid;
    end

    assign push_sel[k]  = push && (widx == CW'(k));
    assign dwr_sel[k]   = dwr.en && (delim_len[IW-1:0] == IW'(k));
    assign delim_act[k] = CW'(k) < delim_len;

    ssc_cell #(.K(k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .push_sel  (push_sel[k]),
      .dwr_sel   (dwr_sel[k]),
      .delim_act (delim_act[k]),
      .nb_byte   (nb_byte),
      .nb_valid  (nb_valid),
      .probe     (stat[1].win_byte),
      .stat      (stat[k])
    );

    assign delim_ok_v[k]  = stat[k].delim_ok;
    assign delim_has_v[k] = stat[k].delim_has;
    assign kw_ok_v[k]     = stat[k].kw_ok;
  end

  assign hv.head        = stat[0].win_byte;
  assign hv.next_byte   = stat[1].win_byte;
  assign hv.next_valid  = stat[1].valid;
  assign hv.delim_match = (delim_len != '0) && (&delim_ok_v);
  assign hv.kw_match    = &kw_ok_v;
  assign hv.delim_has   = |delim_has_v;

  ssc_label #(.WINDOW(WINDOW)) u_label (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .restart   (final_byte),
    .hv        (hv),
    .cls       (cls),
    .delim_len (delim_len),
    .dwr       (dwr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      flush_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (push && in_ch.is_last) begin
        flush_r <= 1'b1;
      end else if (go && final_byte) begin
        flush_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_class_r <= cls;
      out_char_r  <= stat[0].win_byte;
      out_last_r  <= final_byte;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.char_class = out_class_r;
  assign out_ch.char_out   = out_char_r;
  assign out_ch.last_out   = out_last_r;

endmodule
`default_nettype wire

@@ rtl/ssc_checker.sv @@
// Port-level checks for the classifier and the bind that attaches them.
// Depends on ssc_pkg and sql_script_char_classifier.
`timescale 1ns / 1ps
`default_nettype none
module ssc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_is_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_char_class,
  input logic [7:0] out_char_out,
  input logic       out_last_out
);

  // A stalled result word must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_class) &&
                                $stable(out_char_out) && $stable(out_last_out))
    else $error("result word changed while stalled");

  a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_char_class != ssc_pkg::CLS_NONE)
    else $error("result carries no class");

  // Taking the last byte of a script starts a flush that holds off input.
  a_flush_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_last |=> !in_ready)
    else $error("input taken right after a last byte");

endmodule

bind sql_script_char_classifier ssc_checker u_ssc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_is_last     (in_ch.is_last),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_char_class (out_ch.char_class),
  .out_char_out   (out_ch.char_out),
  .out_last_out   (out_ch.last_out)
);
`default_nettype wire

@@ bench/sql_script_char_classifier_tb.sv @@
// Self-checking bench for sql_script_char_classifier: streams SQL scripts, predicts
// each byte's label in the bench and compares every labeled word as it leaves.
// Depends on ssc_pkg, ssc_in_if, ssc_out_if and the classifier RTL.
`timescale 1ns / 1ps
module sql_script_char_classifier_tb;

  localparam int WIN          = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 310;
  localparam string KEYWORD   = "DELIMITER";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [2:0] cls;
    logic [7:0] ch;
    logic       last;
  } label_t;

  logic clk;
  logic rst_n;

  ssc_in_if  in_ch ();
  ssc_out_if out_ch ();

  sql_script_char_classifier #(.WINDOW(WIN)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state, one copy of what the block keeps between bytes.
  logic [7:0]  win_q [WIN];
  int unsigned win_fill;
  logic [7:0]  delim_q [WIN];
  int unsigned delim_len;
  logic [2:0]  cur_cls;
  logic [2:0]  pend_cls;
  logic        bs_odd;
  logic [7:0]  prev_ch;

  in_word_t    send_q [$];
  label_t      label_expect [$];
  logic [7:0]  script_q [$];
  logic [7:0]  gen_delim [$];

  int unsigned words_queued, words_accepted, scripts_queued;
  int unsigned labels_checked, fail_count, cycle_count;
  int unsigned class_seen [8];

  logic        in_fire, out_fire;
  logic        send_burst, take_burst;
  int unsigned send_gap, take_stall;
  in_word_t    next_word;
  label_t      want;

  function automatic logic blank_char(logic [7:0] c);
    return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h85 || c == 8'hA0;
  endfunction

  function automatic void clear_script_state();
    foreach (win_q[k]) win_q[k] = '0;
    foreach (delim_q[k]) delim_q[k] = '0;
    delim_q[0] = ssc_pkg::CH_SEMI;
    delim_len  = 1;
    win_fill   = 0;
    cur_cls    = ssc_pkg::CLS_QUERY;
    pend_cls   = ssc_pkg::CLS_NONE;
    bs_odd     = 1'b0;
    prev_ch    = '0;
  endfunction

  // Labels the oldest byte in the window; avail counts the bytes visible to it.
  function automatic logic [2:0] label_oldest(int unsigned avail);
    logic [7:0]  c;
    logic [7:0]  up;
    logic        hit;
    int unsigned k;
    c = win_q[0];
    if (pend_cls != ssc_pkg::CLS_NONE) begin
      cur_cls  = pend_cls;
      pend_cls = ssc_pkg::CLS_NONE;
    end
    case (cur_cls)
      ssc_pkg::CLS_QUERY: begin
        hit = (delim_len != 0) && (avail >= delim_len);
        for (k = 0; k < delim_len && k < WIN; k++)
          if (win_q[k] != delim_q[k]) hit = 1'b0;
        if (hit) begin
          cur_cls = ssc_pkg::CLS_DELIM;
          if (delim_len == 1) pend_cls = ssc_pkg::CLS_QUERY;
        end else if (c == ssc_pkg::CH_LOW_D || c == ssc_pkg::CH_UP_D) begin
          hit = (avail >= ssc_pkg::KEYWORD_LEN);
          for (k = 0; k < ssc_pkg::KEYWORD_LEN; k++) begin
            up = (win_q[k] >= "a" && win_q[k] <= "z") ? win_q[k] - 8'd32 : win_q[k];
            if (up != KEYWORD[k]) hit = 1'b0;
          end
          if (hit) cur_cls = ssc_pkg::CLS_KEYWORD;
        end else if (c == ssc_pkg::CH_SLASH) begin
          if (avail >= 2 && win_q[1] == ssc_pkg::CH_STAR) cur_cls = ssc_pkg::CLS_BLOCK;
        end else if (c == ssc_pkg::CH_DASH) begin
          if (avail >= 2 && win_q[1] == ssc_pkg::CH_DASH) cur_cls = ssc_pkg::CLS_LINE;
        end else if (c == ssc_pkg::CH_QUOTE) begin
          cur_cls = ssc_pkg::CLS_STRING;
        end
      end
      ssc_pkg::CLS_DELIM: begin
        if (avail > 1) begin
          hit = 1'b0;
          for (k = 0; k < delim_len && k < WIN; k++)
            if (delim_q[k] == win_q[1]) hit = 1'b1;
          if (!hit) pend_cls = ssc_pkg::CLS_QUERY;
        end
      end
      ssc_pkg::CLS_STRING: begin
        if (c == ssc_pkg::CH_QUOTE && !bs_odd) pend_cls = ssc_pkg::CLS_QUERY;
      end
      ssc_pkg::CLS_LINE: begin
        if (c == ssc_pkg::CH_LF) cur_cls = ssc_pkg::CLS_QUERY;
      end
      ssc_pkg::CLS_BLOCK: begin
        if (c == ssc_pkg::CH_SLASH && prev_ch == ssc_pkg::CH_STAR) begin
          pend_cls = ssc_pkg::CLS_QUERY;
        end
      end
      ssc_pkg::CLS_KEYWORD: begin
        if (blank_char(c)) begin
          delim_len = 0;
          pend_cls  = ssc_pkg::CLS_VALUE;
        end
      end
      ssc_pkg::CLS_VALUE: begin
        if (blank_char(c)) begin
          pend_cls = ssc_pkg::CLS_QUERY;
        end else if (delim_len < WIN) begin
          delim_q[delim_len] = c;
          delim_len++;
        end
      end
      default: cur_cls = ssc_pkg::CLS_QUERY;
    endcase
    bs_odd  = (c == ssc_pkg::CH_BSLASH) ? ~bs_odd : 1'b0;
    prev_ch = c;
    return cur_cls;
  endfunction

  // Takes one accepted word and queues every label it releases.
  function automatic void classify_step(logic [7:0] c, logic last);
    label_t      r;
    int unsigned n;
    int unsigned k;
    if (win_fill < WIN) begin
      win_q[win_fill] = c;
      win_fill++;
    end
    n = last ? win_fill : ((win_fill >= WIN) ? 1 : 0);
    repeat (n) begin
      r.ch   = win_q[0];
      r.cls  = label_oldest(win_fill);
      r.last = last && (win_fill == 1);
      label_expect.push_back(r);
      for (k = 0; k + 1 < WIN; k++) win_q[k] = win_q[k + 1];
      win_fill--;
    end
    if (last) clear_script_state();
  endfunction

  // Script text generation.
  task automatic add_text(string s);
    int k;
    for (k = 0; k < s.len(); k++) script_q.push_back(s[k]);
  endtask

  function automatic logic [7:0] rand_printable(logic [7:0] banned_a, logic [7:0] banned_b);
    logic [7:0] b;
    do b = 8'($urandom_range(8'h20, 8'h7E)); while (b == banned_a || b == banned_b);
    return b;
  endfunction

  function automatic logic [7:0] rand_blank();
    logic [7:0] set [8];
    set = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20, 8'h85, 8'hA0};
    return set[$urandom_range(0, 7)];
  endfunction

  task automatic add_delim_command(int unsigned value_len);
    logic [7:0]  b;
    int unsigned k;
    for (k = 0; k < ssc_pkg::KEYWORD_LEN; k++) begin
      b = KEYWORD[k];
      script_q.push_back($urandom_range(0, 1) ? b + 8'd32 : b);
    end
    script_q.push_back(rand_blank());
    gen_delim.delete();
    for (k = 0; k < value_len; k++) begin
      do b = 8'($urandom_range(8'h21, 8'hFF)); while (blank_char(b));
      script_q.push_back(b);
      if (k < WIN) gen_delim.push_back(b);
    end
    script_q.push_back(rand_blank());
  endtask

  task automatic queue_script();
    int unsigned k;
    for (k = 0; k < script_q.size(); k++) begin
      send_q.push_back(in_word_t'{script_q[k], k == script_q.size() - 1});
      words_queued++;
    end
    scripts_queued++;
    script_q.delete();
  endtask

  // Mostly well-formed SQL with random content; noise bytes break it up now and then.
  task automatic build_random_script(int unsigned idx);
    int unsigned goal, pick, n, k;
    logic [7:0]  b;
    gen_delim = '{ssc_pkg::CH_SEMI};
    goal = ($urandom_range(0, 7) == 0) ? $urandom_range(1, WIN - 1) : $urandom_range(WIN, 70);
    if (idx == 0) add_delim_command(WIN + 2);
    else if (idx == 1) add_delim_command(0);
    while (script_q.size() < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        n = $urandom_range(1, 6);
        repeat (n) script_q.push_back($urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                                                           : 8'($urandom_range("0", "9")));
      end else if (pick < 40) begin
        repeat ($urandom_range(1, 2)) script_q.push_back(rand_blank());
      end else if (pick < 55) begin
        if (gen_delim.size() == 0) begin
          script_q.push_back(ssc_pkg::CH_SEMI);
        end else begin
          for (k = 0; k < gen_delim.size(); k++) script_q.push_back(gen_delim[k]);
        end
      end else if (pick < 65) begin
        script_q.push_back(ssc_pkg::CH_QUOTE);
        n = $urandom_range(0, 8);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) begin
            script_q.push_back(ssc_pkg::CH_BSLASH);
            script_q.push_back(rand_printable(8'h00, 8'h00));
          end else begin
            script_q.push_back(rand_printable(ssc_pkg::CH_QUOTE, ssc_pkg::CH_BSLASH));
          end
        end
        script_q.push_back(ssc_pkg::CH_QUOTE);
      end else if (pick < 72) begin
        add_text("--");
        repeat ($urandom_range(0, 8)) begin
          script_q.push_back(rand_printable(ssc_pkg::CH_STAR, ssc_pkg::CH_STAR));
        end
        script_q.push_back(ssc_pkg::CH_LF);
      end else if (pick < 80) begin
        add_text("/*");
        repeat ($urandom_range(0, 8)) begin
          script_q.push_back(rand_printable(ssc_pkg::CH_STAR, ssc_pkg::CH_STAR));
        end
        add_text("*/");
      end else if (pick < 88) begin
        k = $urandom_range(0, 9);
        add_delim_command((k == 0) ? 0 : (k == 1) ? $urandom_range(WIN - 1, WIN + 4)
                                                  : $urandom_range(1, 3));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          b = 8'($urandom_range(0, 255));
          script_q.push_back(b);
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (words_accepted != words_queued || label_expect.size() != 0) @(negedge clk);
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_byte = '0;
    in_ch.is_last   = 1'b0;
    out_ch.ready    = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender: holds a word until it is taken, then idles for its drawn gap.
  always @(negedge clk) begin
    if (rst_n && !(in_ch.valid && !in_fire)) begin
      if (send_gap != 0) begin
        in_ch.valid <= 1'b0;
        send_gap--;
      end else if (send_q.size() != 0) begin
        next_word = send_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.char_byte <= next_word.ch;
        in_ch.is_last   <= next_word.last;
        if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 5);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls a drawn number of cycles before each word.
  always @(negedge clk) begin
    if (out_fire) begin
      if ($urandom_range(0, 15) == 0) take_burst = ~take_burst;
      take_stall = take_burst ? 0 : $urandom_range(0, 5);
    end
    if (take_stall != 0) begin
      out_ch.ready <= 1'b0;
      take_stall--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    in_fire  = rst_n && in_ch.valid && in_ch.ready;
    out_fire = rst_n && out_ch.valid && out_ch.ready;
    if (in_fire) begin
      words_accepted++;
      classify_step(in_ch.char_byte, in_ch.is_last);
    end
    if (out_fire) begin
      if (label_expect.size() == 0) begin
        $display("%0t: unexpected word class=%0d byte=%02h last=%0b", $time,
                 out_ch.char_class, out_ch.char_out, out_ch.last_out);
        fail_count++;
      end else begin
        want = label_expect.pop_front();
        if ({out_ch.char_class, out_ch.char_out, out_ch.last_out} !== want) begin
          $display("%0t: expected cls=%0d byte=%02h last=%0b, got cls=%0d byte=%02h last=%0b",
                   $time, want.cls, want.ch, want.last,
                   out_ch.char_class, out_ch.char_out, out_ch.last_out);
          fail_count++;
        end
        labels_checked++;
        class_seen[want.cls]++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d labels outstanding", $time, label_expect.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned script_idx;
    clear_script_state();
    send_burst = 1'b0;
    take_burst = 1'b0;
    send_gap   = 0;
    take_stall = 0;
    in_fire    = 1'b0;
    out_fire   = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Delimiter as the final byte, lower-case keyword with a one-byte value,
    // byte extremes with a D cut short, and an escaped quote inside a string.
    add_text("x;");
    queue_script();
    add_text("delimiter |\n-");
    queue_script();
    script_q = '{8'hFF, 8'h00, 8'h80, ssc_pkg::CH_UP_D};
    queue_script();
    add_text("'\\''");
    queue_script();
    wait_drained();

    script_idx = 0;
    while (words_queued + 23 < RANDOM_WORDS) begin
      build_random_script(script_idx);
      queue_script();
      script_idx++;
    end
    wait_drained();
    repeat (WIN + 8) @(negedge clk);

    $display("Checked %0d labels from %0d bytes in %0d scripts, %0d cycles.",
             labels_checked, words_accepted, scripts_queued, cycle_count);
    $display("By class: query %0d delim %0d string %0d line %0d block %0d kw %0d value %0d",
             class_seen[ssc_pkg::CLS_QUERY], class_seen[ssc_pkg::CLS_DELIM],
             class_seen[ssc_pkg::CLS_STRING], class_seen[ssc_pkg::CLS_LINE],
             class_seen[ssc_pkg::CLS_BLOCK], class_seen[ssc_pkg::CLS_KEYWORD],
             class_seen[ssc_pkg::CLS_VALUE]);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
